@@ src/matrix_inverse_3x3_macros.svh @@
// Assertion macros shared by the matrix inverse checker.
// No dependencies; include by bare file name.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Same-cycle implication under active-low reset.
`define MI3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix inverse assertion failed");

// Next-cycle implication under active-low reset.
`define MI3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix inverse assertion failed");

`endif

@@ src/mi3_pkg.sv @@
// Shared constants and types for the 3x3 matrix inverse pipeline.
// No dependencies.
`default_nettype none
package mi3_pkg;
  localparam int DET_W   = 64;
  localparam int THR_W   = 63;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  localparam logic [PADDR_W-1:0] ADDR_THR  = 4'h0;
  localparam logic [THR_W-1:0]   THR_RESET = 63'd1;
  localparam logic [DET_W-1:0]   DET_MAX   = {1'b0, {(DET_W-1){1'b1}}};
  localparam logic [DET_W-1:0]   DET_MIN   = {1'b1, {(DET_W-1){1'b0}}};

  typedef struct packed {
    logic singular;
    logic det_sat;
  } det_flags_t;
endpackage
`default_nettype wire

@@ src/mi3_cof.sv @@
// Cofactor stage pair: products of element pairs, then adjugate differences.
// Depends on nothing but its parameters.
`default_nettype none
module mi3_cof #(
  parameter int E = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [E-1:0]   a [9],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [2*E:0]   adj [9],
  output logic signed [E-1:0]   row0 [3]
);
  localparam int PW = 2 * E;
  localparam int AW = 2 * E + 1;
  localparam int NS = 2;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  logic signed [PW-1:0] pa_r [9];
  logic signed [PW-1:0] pb_r [9];
  logic signed [AW-1:0] adj_r [9];
  logic signed [E-1:0]  r0a_r [3];
  logic signed [E-1:0]  r0b_r [3];

  assign rdy[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end
  assign vin = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= vin[s];
        end
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      always_ff @(posedge clk) begin
        if (rdy[0]) begin
          pa_r[r*3+c] <= PW'(a[C1*3+R1]) * PW'(a[C2*3+R2]);
          pb_r[r*3+c] <= PW'(a[C1*3+R2]) * PW'(a[C2*3+R1]);
        end
        if (rdy[1]) begin
          adj_r[r*3+c] <= AW'(pa_r[r*3+c]) - AW'(pb_r[r*3+c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      r0a_r <= a[0:2];
    end
    if (rdy[1]) begin
      r0b_r <= r0a_r;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign adj       = adj_r;
  assign row0      = r0b_r;
endmodule
`default_nettype wire

@@ src/mi3_det.sv @@
// Determinant stages: split products, column sums, rounding, saturation, singular test.
// Depends on mi3_pkg.
`default_nettype none
module mi3_det #(
  parameter int E = 32,
  parameter int F = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [E-1:0]           row0 [3],
  input  logic signed [2*E:0]           adj [9],
  input  logic [mi3_pkg::THR_W-1:0]     thr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [2*E:0]           adj_o [9],
  output logic                          dneg,
  output logic [3*E+1-F:0]              dabs,
  output logic [mi3_pkg::DET_W-1:0]     dbits,
  output mi3_pkg::det_flags_t           flags
);
  import mi3_pkg::*;

  localparam int AW  = 2 * E + 1;
  localparam int PPW = 2 * E + 2;
  localparam int XW  = 3 * E + 2;
  localparam int QW  = XW - F;
  localparam int NS  = 5;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  logic signed [AW-1:0]  adj_r [NS][9];
  logic signed [PPW-1:0] plo_r [3];
  logic signed [PPW-1:0] phi_r [3];
  logic signed [XW-1:0]  col_r [3];
  logic signed [QW-1:0]  dq_r;
  logic [DET_W-1:0]      dbits3_r;
  logic [QW-1:0]         dabs3_r;
  logic                  dneg3_r;
  logic                  dsat3_r;
  logic [DET_W-1:0]      dbits4_r;
  logic [QW-1:0]         dabs4_r;
  logic                  dneg4_r;
  det_flags_t            flags4_r;

  logic signed [XW-1:0]  rnd_c;
  logic                  sat_c;
  logic [DET_W-1:0]      dbits_c;
  logic [DET_W-1:0]      mag_c;

  assign rdy[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end
  assign vin = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= vin[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      adj_r[0] <= adj;
    end
    for (int s = 1; s < NS; s++) begin
      if (rdy[s]) begin
        adj_r[s] <= adj_r[s-1];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_col
    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        plo_r[c] <= PPW'(row0[c]) * PPW'($signed({1'b0, adj[c*3][E-1:0]}));
        phi_r[c] <= PPW'(row0[c]) * PPW'($signed(adj[c*3][AW-1:E]));
      end
      if (rdy[1]) begin
        col_r[c] <= (XW'(phi_r[c]) <<< E) + XW'(plo_r[c]);
      end
    end
  end

  assign rnd_c = col_r[0] + col_r[1] + col_r[2] + (XW'(1) <<< (F - 1));

  if (QW >= DET_W) begin : g_sat
    logic [QW-DET_W:0] top_c;
    assign top_c   = dq_r[QW-1:DET_W-1];
    assign sat_c   = !((&top_c) || !(|top_c));
    assign dbits_c = sat_c ? (dq_r[QW-1] ? DET_MIN : DET_MAX) : dq_r[DET_W-1:0];
  end else begin : g_ext
    assign sat_c   = 1'b0;
    assign dbits_c = DET_W'(dq_r);
  end

  assign mag_c = dbits3_r[DET_W-1] ? (DET_W'(0) - dbits3_r) : dbits3_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dq_r <= rnd_c[XW-1:F];
    end
    if (rdy[3]) begin
      dbits3_r <= dbits_c;
      dsat3_r  <= sat_c;
      dneg3_r  <= dq_r[QW-1];
      dabs3_r  <= dq_r[QW-1] ? QW'(-dq_r) : QW'(dq_r);
    end
    if (rdy[4]) begin
      dbits4_r          <= dbits3_r;
      dabs4_r           <= dabs3_r;
      dneg4_r           <= dneg3_r;
      flags4_r.det_sat  <= dsat3_r;
      flags4_r.singular <= (mag_c == '0) || (mag_c < DET_W'(thr));
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign adj_o     = adj_r[NS-1];
  assign dneg      = dneg4_r;
  assign dabs      = dabs4_r;
  assign dbits     = dbits4_r;
  assign flags     = flags4_r;
endmodule
`default_nettype wire

@@ src/mi3_div.sv @@
// Nine-lane restoring divider pipeline: rounding offset, overflow check, one quotient bit per
// stage, then sign, saturation and output register. Depends on mi3_pkg.
`default_nettype none
module mi3_div #(
  parameter int E = 32,
  parameter int F = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [2*E:0]           adj [9],
  input  logic                          dneg,
  input  logic [3*E+1-F:0]              dabs,
  input  logic [mi3_pkg::DET_W-1:0]     dbits,
  input  mi3_pkg::det_flags_t           flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [E-1:0]           inv [9],
  output logic [mi3_pkg::DET_W-1:0]     det,
  output logic                          singular,
  output logic                          saturated
);
  import mi3_pkg::*;

  localparam int AW   = 2 * E + 1;
  localparam int QW   = 3 * E + 2 - F;
  localparam int NWA  = 2 * E + F + 1;
  localparam int NWB  = 3 * E + 2 - F;
  localparam int DVW  = ((NWA > NWB) ? NWA : NWB) + 2;
  localparam int CW   = DVW + E;
  localparam int NS   = E + 3;
  localparam logic [E-1:0] EMAX = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] EMIN = {1'b1, {(E-1){1'b0}}};

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  logic [DVW-1:0]   rem_r   [NS-1][9];
  logic [E-1:0]     q_r     [NS-1][9];
  logic             ovf_r   [NS-1][9];
  logic             neg_r   [NS-1][9];
  logic [DVW-1:0]   den_r   [NS-1];
  logic [DET_W-1:0] dbits_r [NS-1];
  det_flags_t       flags_r [NS-1];

  logic [AW-1:0]    abs_c [9];
  logic [E-1:0]     val_c [9];
  logic [8:0]       lsat_c;

  logic signed [E-1:0] inv_r [9];
  logic [DET_W-1:0]    det_r;
  logic                sing_r;
  logic                sat_r;

  assign rdy[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end
  assign vin = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= vin[s];
        end
      end
    end
  end

  for (genvar l = 0; l < 9; l++) begin : g_abs
    assign abs_c[l] = adj[l][AW-1] ? AW'(-adj[l]) : AW'(adj[l]);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < 9; l++) begin
        rem_r[0][l] <= (DVW'(abs_c[l]) << (F + 1)) + DVW'(dabs);
        neg_r[0][l] <= adj[l][AW-1] ^ dneg;
        q_r[0][l]   <= '0;
        ovf_r[0][l] <= 1'b0;
      end
      den_r[0]   <= DVW'(dabs) << 1;
      dbits_r[0] <= dbits;
      flags_r[0] <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < 9; l++) begin
        rem_r[1][l] <= rem_r[0][l];
        neg_r[1][l] <= neg_r[0][l];
        q_r[1][l]   <= q_r[0][l];
        ovf_r[1][l] <= CW'(rem_r[0][l]) >= (CW'(den_r[0]) << E);
      end
      den_r[1]   <= den_r[0];
      dbits_r[1] <= dbits_r[0];
      flags_r[1] <= flags_r[0];
    end
  end

  for (genvar s = 2; s < NS - 1; s++) begin : g_bit
    localparam int K = NS - 2 - s;
    for (genvar l = 0; l < 9; l++) begin : g_l
      logic [CW-1:0] dsh_c;
      logic [CW-1:0] sub_c;
      logic          take_c;
      assign dsh_c  = CW'(den_r[s-1]) << K;
      assign take_c = CW'(rem_r[s-1][l]) >= dsh_c;
      assign sub_c  = CW'(rem_r[s-1][l]) - dsh_c;
      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          rem_r[s][l] <= take_c ? sub_c[DVW-1:0] : rem_r[s-1][l];
          q_r[s][l]   <= q_r[s-1][l] | (E'(take_c) << K);
          neg_r[s][l] <= neg_r[s-1][l];
          ovf_r[s][l] <= ovf_r[s-1][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        den_r[s]   <= den_r[s-1];
        dbits_r[s] <= dbits_r[s-1];
        flags_r[s] <= flags_r[s-1];
      end
    end
  end

  for (genvar l = 0; l < 9; l++) begin : g_out
    logic [E-1:0] q_c;
    logic         n_c;
    logic         o_c;
    assign q_c = q_r[NS-2][l];
    assign n_c = neg_r[NS-2][l];
    assign o_c = ovf_r[NS-2][l];
    always_comb begin
      lsat_c[l] = 1'b0;
      val_c[l]  = q_c;
      if (o_c) begin
        lsat_c[l] = 1'b1;
        val_c[l]  = n_c ? EMIN : EMAX;
      end else if (!n_c) begin
        if (q_c[E-1]) begin
          lsat_c[l] = 1'b1;
          val_c[l]  = EMAX;
        end
      end else if (q_c > EMIN) begin
        lsat_c[l] = 1'b1;
        val_c[l]  = EMIN;
      end else begin
        val_c[l] = E'(0) - q_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      for (int l = 0; l < 9; l++) begin
        inv_r[l] <= flags_r[NS-2].singular ? '0 : val_c[l];
      end
      det_r  <= dbits_r[NS-2];
      sing_r <= flags_r[NS-2].singular;
      sat_r  <= flags_r[NS-2].det_sat || (!flags_r[NS-2].singular && (|lsat_c));
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign inv       = inv_r;
  assign det       = det_r;
  assign singular  = sing_r;
  assign saturated = sat_r;
endmodule
`default_nettype wire

@@ src/matrix_inverse_3x3.sv @@
// Top level of the 3x3 matrix inverse: APB threshold register and the
// cofactor, determinant and divider pipelines. Depends on mi3_pkg, mi3_cof, mi3_det, mi3_div.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid/in_ready   | in_a_r0_c0 .. in_a_r2_c2
//   result   | out_valid/out_ready | out_inv_r0_c0 .. out_inv_r2_c2, out_determinant,
//            |                     | out_singular, out_saturated
//   config   | psel/penable/pready | paddr, pwdata, prdata (threshold at 0x0)
//
// One matrix per cycle sustained while out_ready stays high; the divider lanes resolve
// one quotient bit per stage.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets the threshold to 1.
// Each stage holds while the one after it is full and stalled; bubbles close up.
`default_nettype none
module matrix_inverse_3x3 #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r0_c0,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r0_c1,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r0_c2,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r1_c0,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r1_c1,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r1_c2,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r2_c0,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r2_c1,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_a_r2_c2,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r0_c0,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r0_c1,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r0_c2,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r1_c0,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r1_c1,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r1_c2,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r2_c0,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r2_c1,
  output logic signed [ELEMENT_WIDTH-1:0]   out_inv_r2_c2,
  output logic signed [mi3_pkg::DET_W-1:0]  out_determinant,
  output logic                              out_singular,
  output logic                              out_saturated,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mi3_pkg::PADDR_W-1:0]       paddr,
  input  logic [mi3_pkg::PDATA_W-1:0]       pwdata,
  output logic [mi3_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import mi3_pkg::*;

  localparam int E  = ELEMENT_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int AW = 2 * E + 1;
  localparam int QW = 3 * E + 2 - F;

  logic [THR_W-1:0] thr_r;

  logic signed [E-1:0]  a_c [9];
  logic signed [AW-1:0] cof_adj [9];
  logic signed [E-1:0]  cof_row0 [3];
  logic                 cof_valid;
  logic                 det_ready;

  logic signed [AW-1:0] det_adj [9];
  logic                 det_dneg;
  logic [QW-1:0]        det_dabs;
  logic [DET_W-1:0]     det_dbits;
  det_flags_t           det_flags;
  logic                 det_valid;
  logic                 div_ready;

  logic signed [E-1:0]  inv_c [9];
  logic [DET_W-1:0]     det_out;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_THR) ? PDATA_W'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_THR)) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  assign a_c[0] = in_a_r0_c0;
  assign a_c[1] = in_a_r0_c1;
  assign a_c[2] = in_a_r0_c2;
  assign a_c[3] = in_a_r1_c0;
  assign a_c[4] = in_a_r1_c1;
  assign a_c[5] = in_a_r1_c2;
  assign a_c[6] = in_a_r2_c0;
  assign a_c[7] = in_a_r2_c1;
  assign a_c[8] = in_a_r2_c2;

  mi3_cof #(.E(E)) u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a         (a_c),
    .out_valid (cof_valid),
    .out_ready (det_ready),
    .adj       (cof_adj),
    .row0      (cof_row0)
  );

  mi3_det #(.E(E), .F(F)) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cof_valid),
    .in_ready  (det_ready),
    .row0      (cof_row0),
    .adj       (cof_adj),
    .thr       (thr_r),
    .out_valid (det_valid),
    .out_ready (div_ready),
    .adj_o     (det_adj),
    .dneg      (det_dneg),
    .dabs      (det_dabs),
    .dbits     (det_dbits),
    .flags     (det_flags)
  );

  mi3_div #(.E(E), .F(F)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (det_valid),
    .in_ready  (div_ready),
    .adj       (det_adj),
    .dneg      (det_dneg),
    .dabs      (det_dabs),
    .dbits     (det_dbits),
    .flags     (det_flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .inv       (inv_c),
    .det       (det_out),
    .singular  (out_singular),
    .saturated (out_saturated)
  );

  assign out_inv_r0_c0   = inv_c[0];
  assign out_inv_r0_c1   = inv_c[1];
  assign out_inv_r0_c2   = inv_c[2];
  assign out_inv_r1_c0   = inv_c[3];
  assign out_inv_r1_c1   = inv_c[4];
  assign out_inv_r1_c2   = inv_c[5];
  assign out_inv_r2_c0   = inv_c[6];
  assign out_inv_r2_c1   = inv_c[7];
  assign out_inv_r2_c2   = inv_c[8];
  assign out_determinant = det_out;
endmodule
`default_nettype wire

@@ src/mi3_checker.sv @@
// Port-level checker for matrix_inverse_3x3 and its bind.
// Depends on mi3_pkg and matrix_inverse_3x3_macros.svh.
`default_nettype none
`include "matrix_inverse_3x3_macros.svh"
module mi3_checker #(
  parameter int ELEMENT_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic signed [ELEMENT_WIDTH-1:0]   in_a_r0_c0,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r0_c0,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r0_c1,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r0_c2,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r1_c0,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r1_c1,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r1_c2,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r2_c0,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r2_c1,
  input logic signed [ELEMENT_WIDTH-1:0]   out_inv_r2_c2,
  input logic signed [mi3_pkg::DET_W-1:0]  out_determinant,
  input logic                              out_singular,
  input logic                              out_saturated
);
  import mi3_pkg::*;

  `MI3_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_determinant) && $stable(out_singular) && $stable(out_saturated) && $stable(out_inv_r1_c1))
  `MI3_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_a_r0_c0))
  `MI3_ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && out_singular, out_inv_r0_c0 == '0 && out_inv_r0_c1 == '0 && out_inv_r0_c2 == '0 && out_inv_r1_c0 == '0 && out_inv_r1_c1 == '0 && out_inv_r1_c2 == '0 && out_inv_r2_c0 == '0 && out_inv_r2_c1 == '0 && out_inv_r2_c2 == '0)
  `MI3_ASSERT_IMP(a_zero_det, clk, rst_n, out_valid && (out_determinant == '0), out_singular)
endmodule

bind matrix_inverse_3x3 mi3_checker #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mi3_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_a_r0_c0      (in_a_r0_c0),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_inv_r0_c0   (out_inv_r0_c0),
  .out_inv_r0_c1   (out_inv_r0_c1),
  .out_inv_r0_c2   (out_inv_r0_c2),
  .out_inv_r1_c0   (out_inv_r1_c0),
  .out_inv_r1_c1   (out_inv_r1_c1),
  .out_inv_r1_c2   (out_inv_r1_c2),
  .out_inv_r2_c0   (out_inv_r2_c0),
  .out_inv_r2_c1   (out_inv_r2_c1),
  .out_inv_r2_c2   (out_inv_r2_c2),
  .out_determinant (out_determinant),
  .out_singular    (out_singular),
  .out_saturated   (out_saturated)
);
`default_nettype wire

@@ dv/matrix_inverse_3x3_test.sv @@
// Testbench for matrix_inverse_3x3: random and directed 3x3 matrices checked
// against a wide-integer adjugate/determinant predictor. Depends on mi3_pkg.
`timescale 1ns / 100ps
module matrix_inverse_3x3_test;
  import mi3_pkg::*;

  localparam int EW = 32;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef logic [8:0][EW-1:0] matrix_t;
  typedef struct packed {
    logic [8:0][EW-1:0] inv;
    logic [DET_W-1:0]   det;
    logic               sing;
    logic               sat;
  } inverse_t;
  typedef logic signed [159:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  matrix_t in_m = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [8:0][EW-1:0] out_inv;
  logic [DET_W-1:0] out_det;
  logic out_sing, out_sat;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0, prdata;

  logic [THR_W-1:0] threshold = THR_RESET;
  inverse_t expected_inverses[$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_left = 0;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_r0_c0(in_m[0]), .in_a_r0_c1(in_m[1]), .in_a_r0_c2(in_m[2]),
    .in_a_r1_c0(in_m[3]), .in_a_r1_c1(in_m[4]), .in_a_r1_c2(in_m[5]),
    .in_a_r2_c0(in_m[6]), .in_a_r2_c1(in_m[7]), .in_a_r2_c2(in_m[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inv_r0_c0(out_inv[0]), .out_inv_r0_c1(out_inv[1]), .out_inv_r0_c2(out_inv[2]),
    .out_inv_r1_c0(out_inv[3]), .out_inv_r1_c1(out_inv[4]), .out_inv_r1_c2(out_inv[5]),
    .out_inv_r2_c0(out_inv[6]), .out_inv_r2_c1(out_inv[7]), .out_inv_r2_c2(out_inv[8]),
    .out_determinant(out_det), .out_singular(out_sing), .out_saturated(out_sat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] clip(input wide_t v, input int k, inout logic sat);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (k - 1)) - 1;
    lo = -(wide_t'(1) <<< (k - 1));
    if (v > hi) begin
      sat = 1'b1;
      v = hi;
    end else if (v < lo) begin
      sat = 1'b1;
      v = lo;
    end
    return (k == 64) ? v[63:0] : {32'd0, v[31:0]};
  endfunction

  function automatic inverse_t invert_matrix(input matrix_t m, input logic [THR_W-1:0] thr);
    wide_t a[3][3];
    wide_t cof[3][3];
    wide_t d3, dq, dabs, num, q;
    logic [63:0] mag, w;
    inverse_t r;
    logic s;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = {{128{m[i*3+j][EW-1]}}, m[i*3+j]};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cof[i][j] = a[(j+1)%3][(i+1)%3] * a[(j+2)%3][(i+2)%3]
                  - a[(j+1)%3][(i+2)%3] * a[(j+2)%3][(i+1)%3];
    d3 = a[0][0] * cof[0][0] + a[0][1] * cof[1][0] + a[0][2] * cof[2][0];
    dq = (d3 + (wide_t'(1) <<< (FB - 1))) >>> FB;
    s = 1'b0;
    r.det = clip(dq, 64, s);
    mag = r.det[63] ? -r.det : r.det;
    r.sing = (mag == 64'd0) || (mag < {1'b0, thr});
    dabs = (dq < 0) ? -dq : dq;
    for (int k = 0; k < 9; k++) begin
      r.inv[k] = '0;
      if (!r.sing) begin
        num = cof[k/3][k%3] <<< FB;
        q = (((num < 0) ? -num : num) * 2 + dabs) / (dabs * 2);
        if ((num < 0) != (dq < 0)) q = -q;
        w = clip(q, 32, s);
        r.inv[k] = w[31:0];
      end
    end
    r.sat = s;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycle_count);
    fail_count++;
  endtask

  always @(posedge clk) begin
    inverse_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_inverses.size() == 0) begin
        report_mismatch("unexpected transfer", out_det, 64'd0);
      end else begin
        want = expected_inverses.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_inv[k] !== want.inv[k])
            report_mismatch($sformatf("inv_r%0d_c%0d", k/3, k%3), 64'(out_inv[k]),
                            64'(want.inv[k]));
        if (out_det !== want.det) report_mismatch("determinant", out_det, want.det);
        if (out_sing !== want.sing) report_mismatch("singular", 64'(out_sing), 64'(want.sing));
        if (out_sat !== want.sat) report_mismatch("saturated", 64'(out_sat), 64'(want.sat));
      end
    end
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_matrix(input matrix_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_m <= m;
    do @(posedge clk); while (!in_ready);
    expected_inverses.push_back(invert_matrix(m, threshold));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_THR;
    pwdata <= {1'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    threshold = v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(v)) report_mismatch("threshold readback", prdata, PDATA_W'(v));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [EW-1:0] rand_fix(input int span_bits);
    logic [EW-1:0] v;
    logic [EW-1:0] mask;
    v = $urandom;
    mask = EW'((64'd1 << span_bits) - 64'd1);
    if (span_bits < EW) v = ({EW{v[span_bits-1]}} & ~mask) | (v & mask);
    return v;
  endfunction

  function automatic matrix_t random_matrix;
    matrix_t m;
    int kind;
    kind = $urandom_range(99);
    for (int k = 0; k < 9; k++) begin
      if (kind < 40) m[k] = rand_fix(18);
      else if (kind < 60) m[k] = rand_fix(15);
      else if (kind < 72) m[k] = $urandom;
      else if (kind < 82) m[k] = rand_fix(9);
      else m[k] = rand_fix($urandom_range(30, 2));
    end
    if (kind < 40)
      for (int k = 0; k < 9; k += 4)
        m[k] = m[k] + ($urandom_range(1) ? 32'h0004_0000 : -32'h0004_0000);
    if (kind >= 90) begin
      m[6] = m[0];
      m[7] = m[1];
      m[8] = m[2];
    end
    return m;
  endfunction

  task automatic test_directed;
    matrix_t m;
    m = '0;
    m[0] = 32'h0001_0000; m[4] = 32'h0001_0000; m[8] = 32'h0001_0000;
    send_matrix(m);
    m[4] = 32'hFFFE_0000;
    send_matrix(m);
    send_matrix('0);
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({9{32'h8000_0000}});
    m = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    send_matrix(m);
    m = '0;
    m[0] = 32'h8000_0000; m[4] = 32'h8000_0000; m[8] = 32'h8000_0000;
    send_matrix(m);
    m = '0;
    m[0] = 32'd1; m[4] = 32'd1; m[8] = 32'd1;
    send_matrix(m);
    m[0] = 32'd256; m[4] = 32'd256; m[8] = 32'd256;
    send_matrix(m);
    m = '0;
    m[0] = 32'd1; m[4] = 32'h0000_8000; m[8] = 32'd1;
    send_matrix(m);
    m[0] = 32'hFFFF_FFFF;
    send_matrix(m);
    m = '0;
    m[0] = 32'h0003_0000; m[4] = 32'h0003_0000; m[8] = 32'h0003_0000;
    send_matrix(m);
    m = {32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0003_0000,
         32'h0000_4000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000};
    send_matrix(m);
    m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'h0004_0000,
         32'h0006_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000};
    send_matrix(m);
    m = '0;
    m[2] = 32'h0001_0000; m[4] = 32'h0001_0000; m[6] = 32'h0001_0000;
    send_matrix(m);
  endtask

  task automatic test_thresholds;
    logic [THR_W-1:0] settings[6];
    settings = '{63'd0, 63'd1 << 32, {THR_W{1'b1}}, 63'd1 << 20, 63'd0, THR_RESET};
    settings[4] = THR_W'({$urandom, $urandom} >> 1);
    foreach (settings[s]) begin
      write_threshold(settings[s]);
      repeat (30) send_matrix(random_matrix());
    end
  endtask

  task automatic test_idle_phases;
    int idle[4] = '{0, 74, 0, 26};
    int stall[4] = '{0, 0, 74, 26};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle[p];
      stall_pct = stall[p];
      repeat (60) send_matrix(random_matrix());
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure;
    hold_len = 300;
    repeat (80) send_matrix(random_matrix());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_idle_phases();
    test_backpressure();
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+src
src/mi3_pkg.sv
src/mi3_cof.sv
src/mi3_det.sv
src/mi3_div.sv
src/matrix_inverse_3x3.sv
src/mi3_checker.sv
dv/matrix_inverse_3x3_test.sv
